// ===== src/ffa_pkg.sv =====
// shared types and constants of the first-fit heap allocator
// used by ffa_ctrl and first_fit_heap_allocator_core
package ffa_pkg;

	localparam int HEAP_BYTES   = 16384;
	localparam int HEADER_BYTES = 32;
	localparam int MAX_SEGMENTS = 512;

	localparam int ADDR_W = 14;
	localparam int SIZE_W = 15;
	localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
	localparam int IDX_W  = $clog2(MAX_SEGMENTS);
	localparam int ENT_W  = 2 * ADDR_W + 1;

	localparam logic [ADDR_W:0]   HDR_X     = (ADDR_W + 1)'(HEADER_BYTES);
	localparam logic [ADDR_W-1:0] INIT_SIZE = ADDR_W'(HEAP_BYTES - HEADER_BYTES);
	localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_SEGMENTS);

	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_REALLOC = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_NULL    = 2'd2;
	localparam logic [1:0] ST_UNKNOWN = 2'd3;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_FD_RD, S_FD_CHK, S_AL_RD, S_AL_CHK, S_IN_RD, S_IN_WR,
		S_SP_NEW, S_AL_WR, S_RN_RD, S_RN_CHK, S_MG_WR, S_DL_RD, S_DL_WR, S_DONE
	} state_t;

	typedef enum logic [1:0] {M_ALLOC, M_FREE, M_REALLOC, M_REFREE} mode_t;

	typedef struct packed {
		logic              free;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] start;
	} entry_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		entry_t            wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] addr;
		logic              copy_needed;
		logic [ADDR_W-1:0] copy_len;
	} result_t;

endpackage

// ===== src/ffa_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module ffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/ffa_ctrl.sv =====
// sequencer of the allocator: scans, inserts and deletes segment table entries
// depends on ffa_pkg; drives the segment table ram through a ffa_pkg::mem_req_t
module ffa_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                cmd,
	input  logic [ffa_pkg::ADDR_W-1:0] req_addr,
	input  logic [ffa_pkg::SIZE_W-1:0] req_size,
	output ffa_pkg::mem_req_t          mem_req,
	input  ffa_pkg::entry_t            rdata,
	output logic                      res_valid,
	input  logic                      res_ready,
	output ffa_pkg::result_t           res
);

	ffa_pkg::state_t state_q, state_d;
	ffa_pkg::mode_t  mode_q, mode_d;

	logic [ffa_pkg::CNT_W-1:0]  cnt_q, cnt_d, i_q, i_d, j_q, j_d, k_q, k_d;
	logic [ffa_pkg::IDX_W-1:0]  idx_q, idx_d;
	logic [ffa_pkg::ADDR_W-1:0] a_q, a_d;
	logic [ffa_pkg::SIZE_W-1:0] sz_q, sz_d;
	logic [ffa_pkg::ADDR_W-1:0] e_start_q, e_start_d, e_size_q, e_size_d;
	logic [ffa_pkg::ADDR_W-1:0] f_start_q, f_start_d, f_size_q, f_size_d;
	logic [ffa_pkg::ADDR_W-1:0] j_start_q, j_start_d;
	logic                       split_q, split_d;
	ffa_pkg::result_t           res_q, res_d;

	logic [ffa_pkg::CNT_W-1:0]  idx_x, span;
	logic [ffa_pkg::ADDR_W:0]   seg_end, f_rest;

	assign idx_x   = {1'b0, idx_q};
	assign span    = idx_x - j_q;
	assign seg_end = {1'b0, e_start_q} + ffa_pkg::HDR_X + {1'b0, e_size_q};
	assign f_rest  = {1'b0, f_size_q} - sz_q;
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffa_pkg::S_INIT;
			mode_q  <= ffa_pkg::M_ALLOC;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		a_q       <= a_d;
		sz_q      <= sz_d;
		e_start_q <= e_start_d;
		e_size_q  <= e_size_d;
		f_start_q <= f_start_d;
		f_size_q  <= f_size_d;
		j_start_q <= j_start_d;
		split_q   <= split_d;
		res_q     <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		i_d       = i_q;
		j_d       = j_q;
		k_d       = k_q;
		idx_d     = idx_q;
		a_d       = a_q;
		sz_d      = sz_q;
		e_start_d = e_start_q;
		e_size_d  = e_size_q;
		f_start_d = f_start_q;
		f_size_d  = f_size_q;
		j_start_d = j_start_q;
		split_d   = split_q;
		res_d     = res_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mem_req   = '0;
		case (state_q)
			ffa_pkg::S_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.wdata = '{free: 1'b1, size: ffa_pkg::INIT_SIZE, start: '0};
				cnt_d         = ffa_pkg::CNT_W'(1);
				state_d       = ffa_pkg::S_IDLE;
			end
			ffa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					a_d   = req_addr;
					sz_d  = req_size;
					i_d   = '0;
					res_d = '{status: ffa_pkg::ST_OK, addr: '0, copy_needed: 1'b0,
						copy_len: '0};
					case (cmd)
						ffa_pkg::CMD_ALLOC: begin
							mode_d  = ffa_pkg::M_ALLOC;
							state_d = ffa_pkg::S_AL_RD;
						end
						ffa_pkg::CMD_FREE: begin
							if (req_addr == '0) begin
								res_d.status = ffa_pkg::ST_NULL;
								state_d      = ffa_pkg::S_DONE;
							end else begin
								mode_d  = ffa_pkg::M_FREE;
								state_d = ffa_pkg::S_FD_RD;
							end
						end
						ffa_pkg::CMD_REALLOC: begin
							if (req_addr == '0) begin
								mode_d  = ffa_pkg::M_ALLOC;
								state_d = ffa_pkg::S_AL_RD;
							end else begin
								mode_d  = ffa_pkg::M_REALLOC;
								state_d = ffa_pkg::S_FD_RD;
							end
						end
						default: state_d = ffa_pkg::S_DONE;
					endcase
				end
			end
			// look up the segment whose payload starts at the request address
			ffa_pkg::S_FD_RD: begin
				mem_req.raddr = i_q[ffa_pkg::IDX_W-1:0];
				if (i_q == cnt_q) begin
					if (mode_q != ffa_pkg::M_REFREE) begin
						res_d.status = ffa_pkg::ST_UNKNOWN;
					end
					state_d = ffa_pkg::S_DONE;
				end else begin
					state_d = ffa_pkg::S_FD_CHK;
				end
			end
			ffa_pkg::S_FD_CHK: begin
				if ({1'b0, rdata.start} + ffa_pkg::HDR_X == {1'b0, a_q}) begin
					idx_d     = i_q[ffa_pkg::IDX_W-1:0];
					e_start_d = rdata.start;
					e_size_d  = rdata.size;
					if (mode_q == ffa_pkg::M_REALLOC) begin
						if ({1'b0, rdata.size} >= sz_q) begin
							res_d.addr = a_q;
							state_d    = ffa_pkg::S_DONE;
						end else begin
							i_d     = '0;
							state_d = ffa_pkg::S_AL_RD;
						end
					end else begin
						j_d     = i_q;
						state_d = ffa_pkg::S_RN_RD;
					end
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ffa_pkg::S_FD_RD;
				end
			end
			// first-fit scan
			ffa_pkg::S_AL_RD: begin
				mem_req.raddr = i_q[ffa_pkg::IDX_W-1:0];
				if (i_q == cnt_q) begin
					res_d.status = ffa_pkg::ST_NOMEM;
					res_d.addr   = '0;
					state_d      = ffa_pkg::S_DONE;
				end else begin
					state_d = ffa_pkg::S_AL_CHK;
				end
			end
			ffa_pkg::S_AL_CHK: begin
				if (rdata.free && {1'b0, rdata.size} >= sz_q) begin
					idx_d      = i_q[ffa_pkg::IDX_W-1:0];
					f_start_d  = rdata.start;
					f_size_d   = rdata.size;
					res_d.addr = ffa_pkg::ADDR_W'({1'b0, rdata.start} + ffa_pkg::HDR_X);
					split_d    = 1'b0;
					k_d        = cnt_q;
					state_d    = ffa_pkg::S_AL_WR;
					if (({1'b0, rdata.size} - sz_q) > ffa_pkg::HDR_X &&
						cnt_q < ffa_pkg::MAX_CNT) begin
						split_d = 1'b1;
						state_d = ffa_pkg::S_IN_RD;
					end
				end else begin
					i_d     = i_q + 1'b1;
					state_d = ffa_pkg::S_AL_RD;
				end
			end
			// open a hole after the chosen entry, moving the tail up by one
			ffa_pkg::S_IN_RD: begin
				mem_req.raddr = ffa_pkg::IDX_W'(k_q - 1'b1);
				if (k_q <= idx_x + 1'b1) begin
					state_d = ffa_pkg::S_SP_NEW;
				end else begin
					state_d = ffa_pkg::S_IN_WR;
				end
			end
			ffa_pkg::S_IN_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q[ffa_pkg::IDX_W-1:0];
				mem_req.wdata = rdata;
				k_d           = k_q - 1'b1;
				state_d       = ffa_pkg::S_IN_RD;
			end
			ffa_pkg::S_SP_NEW: begin
				mem_req.we          = 1'b1;
				mem_req.waddr       = idx_q + 1'b1;
				mem_req.wdata.free  = 1'b1;
				mem_req.wdata.start = ffa_pkg::ADDR_W'({1'b0, res_q.addr} + sz_q);
				mem_req.wdata.size  = ffa_pkg::ADDR_W'(f_rest - ffa_pkg::HDR_X);
				cnt_d               = cnt_q + 1'b1;
				state_d             = ffa_pkg::S_AL_WR;
			end
			ffa_pkg::S_AL_WR: begin
				mem_req.we          = 1'b1;
				mem_req.waddr       = idx_q;
				mem_req.wdata.free  = 1'b0;
				mem_req.wdata.start = f_start_q;
				mem_req.wdata.size  = split_q ? sz_q[ffa_pkg::ADDR_W-1:0] : f_size_q;
				if (mode_q == ffa_pkg::M_REALLOC) begin
					res_d.copy_needed = 1'b1;
					res_d.copy_len    = e_size_q;
					mode_d            = ffa_pkg::M_REFREE;
					i_d               = '0;
					state_d           = ffa_pkg::S_FD_RD;
				end else begin
					state_d = ffa_pkg::S_DONE;
				end
			end
			// walk back over the free run before the freed entry
			ffa_pkg::S_RN_RD: begin
				mem_req.raddr = ffa_pkg::IDX_W'(j_q - 1'b1);
				state_d       = (j_q == '0) ? ffa_pkg::S_MG_WR : ffa_pkg::S_RN_CHK;
			end
			ffa_pkg::S_RN_CHK: begin
				if (rdata.free) begin
					j_d       = j_q - 1'b1;
					j_start_d = rdata.start;
					state_d   = ffa_pkg::S_RN_RD;
				end else begin
					state_d = ffa_pkg::S_MG_WR;
				end
			end
			ffa_pkg::S_MG_WR: begin
				mem_req.we         = 1'b1;
				mem_req.wdata.free = 1'b1;
				if (j_q == idx_x) begin
					mem_req.waddr       = idx_q;
					mem_req.wdata.start = e_start_q;
					mem_req.wdata.size  = e_size_q;
					state_d             = ffa_pkg::S_DONE;
				end else begin
					// segments are contiguous, so the merged payload ends where idx ends
					mem_req.waddr       = j_q[ffa_pkg::IDX_W-1:0];
					mem_req.wdata.start = j_start_q;
					mem_req.wdata.size  = ffa_pkg::ADDR_W'(seg_end - {1'b0, j_start_q} -
						ffa_pkg::HDR_X);
					k_d                 = j_q + 1'b1;
					state_d             = ffa_pkg::S_DL_RD;
				end
			end
			// close the gap of merged entries, moving the tail down
			ffa_pkg::S_DL_RD: begin
				mem_req.raddr = ffa_pkg::IDX_W'(k_q + span);
				if (k_q + span >= cnt_q) begin
					cnt_d   = cnt_q - span;
					state_d = ffa_pkg::S_DONE;
				end else begin
					state_d = ffa_pkg::S_DL_WR;
				end
			end
			ffa_pkg::S_DL_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q[ffa_pkg::IDX_W-1:0];
				mem_req.wdata = rdata;
				k_d           = k_q + 1'b1;
				state_d       = ffa_pkg::S_DL_RD;
			end
			ffa_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ffa_pkg::S_IDLE;
				end
			end
			default: state_d = ffa_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== src/first_fit_heap_allocator_core.sv =====
// first-fit heap allocator: segment table ram, sequencer and output register
// depends on ffa_pkg, ffa_ram and ffa_ctrl
// each table entry scanned is read, then checked; each entry moved on a split or merge
// is read, then written back; final writes follow, then the result goes to the output register
// throughput: one item at a time, next accept after the result is moved into the output register
// reset: asynchronous; the init state writes the single free segment, then ready
module first_fit_heap_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_addr[13:0], req_size[28:14], zero pad
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // status[1:0], addr[15:2], copy_needed[16],
	                                   // copy_len[30:17], zero pad
);

	ffa_pkg::mem_req_t mem_req;
	ffa_pkg::entry_t   rdata;
	ffa_pkg::result_t  res, out_q;
	logic              res_valid, res_ready, out_valid_q;

	assign res_ready = !out_valid_q || m_axis_tready;

	ffa_ram #(
		.WIDTH (ffa_pkg::ENT_W),
		.DEPTH (ffa_pkg::MAX_SEGMENTS)
	) u_table (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (s_axis_tuser),
		.req_addr  (s_axis_tdata[13:0]),
		.req_size  (s_axis_tdata[28:14]),
		.mem_req   (mem_req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_q.copy_len, out_q.copy_needed, out_q.addr, out_q.status};

endmodule

// ===== bench/tb_top.sv =====
// testbench of the first-fit heap allocator core: directed, random and table-fill stimulus
// predicts each result with its own segment table; depends on ffa_pkg and the core
module tb_top;

	class allocator_scoreboard;
		int seg_base[ffa_pkg::MAX_SEGMENTS];
		int seg_len[ffa_pkg::MAX_SEGMENTS];
		bit seg_open[ffa_pkg::MAX_SEGMENTS];
		int seg_cnt;
		ffa_pkg::result_t pending_res[$];
		int errors;
		int results_seen;
		int last_addr;
		logic [1:0] last_status;

		function new();
			seg_base[0] = 0;
			seg_len[0]  = ffa_pkg::HEAP_BYTES - ffa_pkg::HEADER_BYTES;
			seg_open[0] = 1;
			seg_cnt     = 1;
			errors      = 0;
		endfunction

		function int find_payload(int a);
			for (int i = 0; i < seg_cnt; i++)
				if (seg_base[i] + ffa_pkg::HEADER_BYTES == a)
					return i;
			return -1;
		endfunction

		function bit take_first_fit(int sz, output int a);
			int i;
			i = 0;
			a = 0;
			while (i < seg_cnt && !(seg_open[i] && seg_len[i] >= sz))
				i++;
			if (i >= seg_cnt)
				return 0;
			seg_open[i] = 0;
			a = seg_base[i] + ffa_pkg::HEADER_BYTES;
			if (seg_len[i] - sz > ffa_pkg::HEADER_BYTES && seg_cnt < ffa_pkg::MAX_SEGMENTS) begin
				for (int k = seg_cnt; k > i + 1; k--) begin
					seg_base[k] = seg_base[k-1];
					seg_len[k]  = seg_len[k-1];
					seg_open[k] = seg_open[k-1];
				end
				seg_base[i+1] = a + sz;
				seg_len[i+1]  = seg_len[i] - sz - ffa_pkg::HEADER_BYTES;
				seg_open[i+1] = 1;
				seg_len[i]    = sz;
				seg_cnt++;
			end
			return 1;
		endfunction

		// release and merge into the free run directly below, never above
		function void release_seg(int idx);
			seg_open[idx] = 1;
			while (idx > 0 && seg_open[idx-1]) begin
				seg_len[idx-1] += seg_len[idx] + ffa_pkg::HEADER_BYTES;
				for (int k = idx; k + 1 < seg_cnt; k++) begin
					seg_base[k] = seg_base[k+1];
					seg_len[k]  = seg_len[k+1];
					seg_open[k] = seg_open[k+1];
				end
				seg_cnt--;
				idx--;
			end
		endfunction

		function void note_request(logic [1:0] cmd, logic [13:0] ra, logic [14:0] rs);
			ffa_pkg::result_t r;
			int idx;
			int a;
			int old_len;
			r = '0;
			a = 0;
			if (cmd == ffa_pkg::CMD_ALLOC || (cmd == ffa_pkg::CMD_REALLOC && ra == 0)) begin
				if (take_first_fit(int'(rs), a))
					r.addr = 14'(a);
				else
					r.status = ffa_pkg::ST_NOMEM;
			end else if (cmd == ffa_pkg::CMD_FREE) begin
				if (ra == 0) begin
					r.status = ffa_pkg::ST_NULL;
				end else begin
					idx = find_payload(int'(ra));
					if (idx < 0)
						r.status = ffa_pkg::ST_UNKNOWN;
					else
						release_seg(idx);
				end
			end else if (cmd == ffa_pkg::CMD_REALLOC) begin
				idx = find_payload(int'(ra));
				if (idx < 0) begin
					r.status = ffa_pkg::ST_UNKNOWN;
				end else if (seg_len[idx] >= int'(rs)) begin
					r.addr = ra;
				end else begin
					old_len = seg_len[idx];
					if (!take_first_fit(int'(rs), a)) begin
						r.status = ffa_pkg::ST_NOMEM;
					end else begin
						r.addr        = 14'(a);
						r.copy_needed = 1'b1;
						r.copy_len    = 14'(old_len);
						idx = find_payload(int'(ra));
						if (idx >= 0)
							release_seg(idx);
					end
				end
			end
			last_addr   = int'(r.addr);
			last_status = r.status;
			pending_res.push_back(r);
		endfunction

		function void check_result(logic [31:0] d);
			ffa_pkg::result_t e;
			results_seen++;
			if (pending_res.size() == 0) begin
				$error("result with no request outstanding: %h", d);
				errors++;
				return;
			end
			e = pending_res.pop_front();
			if (d[1:0] !== e.status) begin
				$error("status: expected %0d actual %0d", e.status, d[1:0]);
				errors++;
			end
			if (d[15:2] !== e.addr) begin
				$error("addr: expected %0d actual %0d", e.addr, d[15:2]);
				errors++;
			end
			if (d[16] !== e.copy_needed) begin
				$error("copy_needed: expected %0d actual %0d", e.copy_needed, d[16]);
				errors++;
			end
			if (d[30:17] !== e.copy_len) begin
				$error("copy_len: expected %0d actual %0d", e.copy_len, d[30:17]);
				errors++;
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 40000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;

	allocator_scoreboard sb = new();
	bit   steady_phase = 0;
	int   idle_cycles = 0;
	int   items_sent = 0;

	first_fit_heap_allocator_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// receiver back-pressure, mostly short gaps and a few long stalls
	int rx_stall = 0;
	always @(posedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (steady_phase || !arst_n) begin
			m_axis_tready <= arst_n;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_axis_tready <= 0;
		end else if (r < 3) begin
			rx_stall = $urandom_range(20, 120);
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= (r >= 25);
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_request(logic [1:0] cmd, logic [13:0] ra, logic [14:0] rs);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (steady_phase || r < 65)
			gap = 0;
		else if (r < 95)
			gap = $urandom_range(1, 4);
		else
			gap = $urandom_range(20, 100);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {3'b000, rs, ra};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(cmd, ra, rs);
		items_sent++;
	endtask

	// mostly addresses of existing segments, free or not, sometimes noise
	function automatic logic [13:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 14'(sb.seg_base[$urandom_range(0, sb.seg_cnt - 1)] +
				ffa_pkg::HEADER_BYTES);
		else if (r < 85)
			return '0;
		else
			return 14'($urandom_range(0, 16383));
	endfunction

	function automatic logic [14:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 15'($urandom_range(0, 400));
		else if (r < 92)
			return 15'($urandom_range(0, 4000));
		else
			return 15'($urandom_range(0, 32767));
	endfunction

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			send_request(ffa_pkg::CMD_ALLOC, 14'($urandom_range(0, 16383)), pick_size());
		else if (r < 75)
			send_request(ffa_pkg::CMD_FREE, pick_addr(), 15'($urandom_range(0, 32767)));
		else if (r < 97)
			send_request(ffa_pkg::CMD_REALLOC, pick_addr(), pick_size());
		else
			send_request(ffa_pkg::CMD_NONE, 14'($urandom_range(0, 16383)),
				15'($urandom_range(0, 32767)));
	endtask

	initial begin
		int a1;
		int a2;
		int fill_n;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every command and the corner cases
		send_request(ffa_pkg::CMD_ALLOC, 14'd0, 15'd100);
		a1 = sb.last_addr;
		send_request(ffa_pkg::CMD_ALLOC, 14'h3fff, 15'd0);
		send_request(ffa_pkg::CMD_ALLOC, 14'd0, 15'd16384);
		send_request(ffa_pkg::CMD_ALLOC, 14'd0, 15'h7fff);
		send_request(ffa_pkg::CMD_FREE, 14'd0, 15'h7fff);
		send_request(ffa_pkg::CMD_FREE, 14'd5, 15'd0);
		send_request(ffa_pkg::CMD_FREE, 14'h3fff, 15'd0);
		send_request(ffa_pkg::CMD_NONE, 14'h3fff, 15'h7fff);
		send_request(ffa_pkg::CMD_REALLOC, 14'd0, 15'd50);
		send_request(ffa_pkg::CMD_REALLOC, 14'(a1), 15'd50);
		send_request(ffa_pkg::CMD_REALLOC, 14'(a1), 15'd300);
		a2 = sb.last_addr;
		send_request(ffa_pkg::CMD_FREE, 14'(a1), 15'd0);
		send_request(ffa_pkg::CMD_FREE, 14'(a1), 15'd0);
		send_request(ffa_pkg::CMD_REALLOC, 14'd7, 15'd10);
		send_request(ffa_pkg::CMD_REALLOC, 14'(a2), 15'h7fff);
		send_request(ffa_pkg::CMD_REALLOC, 14'(a1), 15'd100);
		send_request(ffa_pkg::CMD_FREE, 14'(a2), 15'd0);
		send_request(ffa_pkg::CMD_ALLOC, 14'd0, 15'd16000);
		send_request(ffa_pkg::CMD_ALLOC, 14'd0, 15'd0);

		for (int n = 0; n < 450; n++) begin
			steady_phase = (n >= 200 && n < 260);
			random_item();
		end
		steady_phase = 0;

		// fill the table with empty payloads until no split is possible
		fill_n = 0;
		while (sb.seg_cnt < ffa_pkg::MAX_SEGMENTS && fill_n < 620) begin
			send_request(ffa_pkg::CMD_ALLOC, 14'd0, 15'd0);
			fill_n++;
		end
		for (int n = 0; n < 40; n++)
			random_item();

		s_axis_tvalid <= 0;
		while (sb.pending_res.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("sent %0d requests, checked %0d results, table fill requests: %0d",
			items_sent, sb.results_seen, fill_n);
		$display("covered alloc, free, realloc, unused command, null and unknown addresses");
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
src/ffa_pkg.sv
src/ffa_ram.sv
src/ffa_ctrl.sv
src/first_fit_heap_allocator_core.sv
bench/tb_top.sv
